// File: src/sha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Types, constants and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load_byte;   // write byte_val into the block buffer
        logic [7:0] byte_val;
        logic       count_inc;   // advance the message byte count
        logic       round_start; // load working vars from hash words
        logic       round_step;  // one compression round
        logic       round_final; // add working vars into hash words
        logic       hash_init;   // restore initial hash, clear count
        logic       len_latch;   // latch bit length for padding
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [5:0] pos;         // byte position in block
        logic [5:0] round;       // current round
        logic [63:0] bits;       // latched bit length
    } t_status;

    localparam logic [5:0] LEN_POS = 6'd56;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// File: src/sha_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for input bytes and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// File: src/sha_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loading, padding, rounds and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_byte_present,
    input  wire logic            i_end_of_message,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_word_index,
    input  wire sha_pkg::t_status i_status,
    output sha_pkg::t_cmd        o_cmd
);
    sha_pkg::t_state r_state, n_state;
    logic            r_eom, n_eom;       // padding pending after this block
    logic            r_final, n_final;   // block in flight is the last one
    logic            r_pad, n_pad;       // zero fill and length still to write
    logic            r_len_here, n_len_here; // length field goes in this block
    logic [2:0]      r_widx, n_widx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha_pkg::ST_IDLE;
            r_eom      <= 1'b0;
            r_final    <= 1'b0;
            r_pad      <= 1'b0;
            r_len_here <= 1'b0;
            r_widx     <= '0;
        end else begin
            r_state    <= n_state;
            r_eom      <= n_eom;
            r_final    <= n_final;
            r_pad      <= n_pad;
            r_len_here <= n_len_here;
            r_widx     <= n_widx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_eom       = r_eom;
        n_final     = r_final;
        n_pad       = r_pad;
        n_len_here  = r_len_here;
        n_widx      = r_widx;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            sha_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_byte = i_byte_present;
                    o_cmd.byte_val  = i_data_byte;
                    o_cmd.count_inc = i_byte_present;
                    n_eom = i_end_of_message;
                    if (i_byte_present && i_status.pos == 6'd63) begin
                        o_cmd.round_start = 1'b1;
                        n_final = 1'b0;
                        n_state = sha_pkg::ST_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                // 0x80 marker; length latched from the count including data
                o_cmd.len_latch = 1'b1;
                o_cmd.load_byte = 1'b1;
                o_cmd.byte_val  = 8'h80;
                n_eom = 1'b0;
                n_state = sha_pkg::ST_LEN;
                if (i_status.pos == 6'd63) begin
                    o_cmd.round_start = 1'b1;
                    n_final = 1'b0;
                    n_state = sha_pkg::ST_ROUND;
                end
                n_pad      = 1'b1;
                n_len_here = (i_status.pos < sha_pkg::LEN_POS);
            end
            sha_pkg::ST_LEN: begin
                o_cmd.load_byte = 1'b1;
                if (!r_len_here || i_status.pos < sha_pkg::LEN_POS) begin
                    o_cmd.byte_val = 8'h00;
                end else begin
                    o_cmd.byte_val = i_status.bits[8'(7 - i_status.pos[2:0]) * 8 +: 8];
                end
                if (i_status.pos == 6'd63) begin
                    o_cmd.round_start = 1'b1;
                    n_final = r_len_here;
                    n_state = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND: begin
                o_cmd.round_step = 1'b1;
                if (i_status.round == 6'd63) n_state = sha_pkg::ST_FINAL;
            end
            sha_pkg::ST_FINAL: begin
                o_cmd.round_final = 1'b1;
                if (r_final) begin
                    n_widx  = '0;
                    n_pad   = 1'b0;
                    n_state = sha_pkg::ST_OUT;
                end else if (r_eom) begin
                    n_state = sha_pkg::ST_PAD;
                end else if (r_pad) begin
                    // marker filled the previous block, length goes in this one
                    n_len_here = 1'b1;
                    n_state    = sha_pkg::ST_LEN;
                end else begin
                    n_state = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        o_cmd.hash_init = 1'b1;
                        n_final = 1'b0;
                        n_state = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    assign o_word_index = r_widx;
endmodule
`default_nettype wire

// File: src/sha_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer as a 16-word shift schedule, working variables, hash words.
// ----------------------------------------------------------------------------
module sha_datapath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sha_pkg::t_cmd  i_cmd,
    input  wire logic [2:0]     i_word_index,
    output logic [31:0]         o_digest_word,
    output sha_pkg::t_status    o_status
);
    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [63:0] r_count;
    logic [63:0] r_bits;
    logic [5:0]  r_pos;
    logic [5:0]  r_round;

    logic [31:0] w_new, t1, t2, s0, s1;

    always_comb begin
        s0    = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        t1 = r_v[7] + (sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
                       ^ sha_pkg::rotr(r_v[4], 25))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha_pkg::ROUND_K[r_round] + r_w[0];
        t2 = (sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13) ^ sha_pkg::rotr(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // buffer words: byte loads go into word pos/4, rounds shift the schedule
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_w[r_pos[5:2]][8'(3 - r_pos[1:0]) * 8 +: 8] <= i_cmd.byte_val;
        end else if (i_cmd.round_step) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_new;
        end
        if (i_cmd.len_latch) r_bits <= {r_count[60:0], 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::IV[i];
            r_count <= '0;
            r_pos   <= '0;
            r_round <= '0;
        end else begin
            if (i_cmd.load_byte) r_pos <= r_pos + 6'd1;
            if (i_cmd.count_inc) r_count <= r_count + 64'd1;
            if (i_cmd.round_start) r_round <= '0;
            else if (i_cmd.round_step) r_round <= r_round + 6'd1;
            if (i_cmd.round_final) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.hash_init) begin
                for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::IV[i];
                r_count <= '0;
                r_pos   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round_start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round_step) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_digest_word   = r_h[i_word_index];
    assign o_status.pos    = r_pos;
    assign o_status.round  = r_round;
    assign o_status.bits   = r_bits;

`ifndef SYNTH
    a_no_load_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round_step |-> !i_cmd.load_byte)
        else $error("byte load during compression");
    a_start_at_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round_start |=> r_pos == 6'd0)
        else $error("compression started on partial block");
    a_round_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round_final |-> $past(i_cmd.round_step) && r_round == 6'd0)
        else $error("final add not after round 63");
`endif
endmodule
`default_nettype wire

// File: src/sha256_stream_hasher_unit.sv
`default_nettype none
// Input: a byte not completing a block is accepted while idle; the byte completing one
// holds off the input through the 64 compression rounds and the hash update.
// End of message: padding bytes one per cycle, then one or two compressions,
// then 8 output words, one per cycle while the sink is ready.
// No input is taken during compression or output; one transaction in flight at a time.
// Reset (synchronous, active low) restores the initial hash and clears the count.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with padding and digest word output.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);
    sha_pkg::t_cmd    cmd;
    sha_pkg::t_status status;
    logic [2:0]       widx;

    sha_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .o_in_ready       (i_in.ready),
        .i_data_byte      (i_in.data_byte),
        .i_byte_present   (i_in.byte_present),
        .i_end_of_message (i_in.end_of_message),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_word_index     (widx),
        .i_status         (status),
        .o_cmd            (cmd)
    );

    sha_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_word_index  (widx),
        .o_digest_word (o_out.digest_word),
        .o_status      (status)
    );

    assign o_out.word_index = widx;
    assign o_out.last_word  = (widx == 3'd7);
endmodule
`default_nettype wire
